### rtl/core/bcss_pkg.sv
// Shared types, constants and helpers for the bad character substring search unit.
package bcss_pkg;

  // Default window depth and fixed alphabet
  localparam int unsigned PatternMaxDef = 16;
  localparam int unsigned AlphabetSize  = 256;
  localparam int unsigned ByteW         = $clog2(AlphabetSize);

  // Configuration port geometry
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned PatLenW     = 5;
  localparam int unsigned PatBytesCfg = 16;
  localparam int unsigned PosW        = 32;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_PAT_LO  = 2'd0,
    CFG_PAT_HI  = 2'd1,
    CFG_PAT_LEN = 2'd2
  } cfg_index_e;

  // Per-transaction control that every cell of the window sees
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // Pick pattern byte k; bytes past the configured storage read as zero
  function automatic logic [ByteW-1:0] pattern_byte(
    input logic [PatBytesCfg*ByteW-1:0] pat,
    input logic [31:0]                  k
  );
    logic [ByteW-1:0] b;
    b = '0;
    if (k < 32'(PatBytesCfg)) begin
      b = pat[k*ByteW +: ByteW];
    end
    return b;
  endfunction

endpackage

### rtl/core/bcss_cell.sv
// One window cell: holds a text byte, passes it on, and checks the byte it receives.
module bcss_cell import bcss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic [ByteW-1:0] want_byte_i,
  input  logic             in_use_i,
  output logic [ByteW-1:0] byte_o,
  output logic             hit_o
);

  logic [ByteW-1:0] byte_q, byte_d;

  // Compare the byte that enters this cell on the current transaction
  assign hit_o = !in_use_i || (byte_i == want_byte_i);

  // Advance the window, drop the contents at end of text
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = ctrl_i.clear ? '0 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

### rtl/core/bad_character_substring_search_unit.sv
// A match is shown on match_valid_o in the cycle after the text byte that ends it is taken.
// Throughput: one text byte per cycle while text_stall_o is low; the cell chain shifts and compares in one step.
// The figure is set by the per-cell byte compare plus the AND over all window cells.
// Reset clears the window, fill count and text position; pattern registers reset
// to zero and the pattern length to one.
module bad_character_substring_search_unit import bcss_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PatternMaxDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 text_valid_i,
  output logic                 text_stall_o,
  input  logic [ByteW-1:0]     text_byte_i,
  input  logic                 end_of_text_i,
  output logic                 match_valid_o,
  input  logic                 match_stall_i,
  output logic [PosW-1:0]      match_start_o
);

  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);

  logic [CfgDataW-1:0] pat_lo_q, pat_hi_q;
  logic [PatLenW-1:0]  pat_len_q;
  logic [LenW-1:0]     fill_q, fill_d, fill_next;
  logic [PosW-1:0]     pos_q, pos_d;
  logic                out_valid_q, out_valid_d;
  logic [PosW-1:0]     out_start_q, out_start_d;

  logic [PatBytesCfg*ByteW-1:0] pat_all;
  logic [LenW-1:0]              eff_len;
  logic                         accept;
  logic                         hit;
  cell_ctrl_t                   ctrl;

  logic [ByteW-1:0] chain    [PATTERN_MAX+1];
  logic [ByteW-1:0] want     [PATTERN_MAX];
  logic             in_use   [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_hit;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= PatLenW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PAT_LO:  pat_lo_q  <= cfg_data_i;
        CFG_PAT_HI:  pat_hi_q  <= cfg_data_i;
        CFG_PAT_LEN: pat_len_q <= cfg_data_i[PatLenW-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all = {pat_hi_q, pat_lo_q};

  // Clamp the length into one to PATTERN_MAX
  always_comb begin
    if (pat_len_q == '0) begin
      eff_len = LenW'(1);
    end else if (32'(pat_len_q) > PATTERN_MAX) begin
      eff_len = LenW'(PATTERN_MAX);
    end else begin
      eff_len = LenW'(pat_len_q);
    end
  end

  // Handshake: take a byte whenever the result register is free or drains
  assign text_stall_o = out_valid_q && match_stall_i;
  assign accept       = text_valid_i && !text_stall_o;
  assign ctrl.shift   = accept;
  assign ctrl.clear   = end_of_text_i;

  // Cell chain: cell k holds the k-th newest byte
  assign chain[0] = text_byte_i;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [LenW-1:0] pidx;
    assign in_use[k] = LenW'(k) < eff_len;
    assign pidx      = eff_len - LenW'(1) - LenW'(k);
    assign want[k]   = pattern_byte(pat_all, 32'(pidx));

    bcss_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .byte_i      (chain[k]),
      .want_byte_i (want[k]),
      .in_use_i    (in_use[k]),
      .byte_o      (chain[k+1]),
      .hit_o       (cell_hit[k])
    );
  end

  // Fill count after this byte, saturating at the window depth
  assign fill_next = (fill_q == LenW'(PATTERN_MAX)) ? fill_q : fill_q + LenW'(1);
  assign hit       = (fill_next >= eff_len) && (&cell_hit);

  // Stream state: advance on each byte, drop at end of text
  always_comb begin
    fill_d = fill_q;
    pos_d  = pos_q;
    if (accept) begin
      if (end_of_text_i) begin
        fill_d = '0;
        pos_d  = '0;
      end else begin
        fill_d = fill_next;
        if (pos_q != '1) begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  // Result register: load on a hit, release when taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_start_d = out_start_q;
    if (out_valid_q && !match_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (accept && hit) begin
      out_valid_d = 1'b1;
      out_start_d = pos_q - PosW'(eff_len - LenW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_start_q <= out_start_d;
  end

  assign match_valid_o = out_valid_q;
  assign match_start_o = out_start_q;

`ifndef SYNTHESIS
  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_text_i |=> fill_q == '0 && pos_q == '0)
    else $error("end of text did not clear stream state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_valid_o && match_stall_i |-> text_stall_o)
    else $error("input taken while a result is held");

  a_short_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && fill_q == '0 && eff_len > LenW'(1) |=> !match_valid_o)
    else $error("match reported before window filled");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= PATTERN_MAX)
    else $error("fill count beyond window depth");

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !end_of_text_i && pos_q == '1 |=> pos_q == '1)
    else $error("text position wrapped");
`endif

endmodule

### sim/tb_bad_character_substring_search_unit.sv
// Testbench for the substring search unit: a directed script, then random text streams.
`timescale 1ns / 1ps

module tb_bad_character_substring_search_unit;
  import bcss_pkg::*;

  localparam int          DrainCycles  = 4;
  localparam int          HoldCycles   = 300;
  localparam int          RandomItems  = 920;
  localparam int unsigned CycleLimit   = 400000;
  localparam logic [CfgIndexW-1:0] CfgIdxSpare = CfgIndexW'(3);

  typedef enum logic {
    ROW_WRITE,
    ROW_TEXT
  } row_kind_e;

  // One line of the directed script: a register write or a run of text bytes
  typedef struct packed {
    row_kind_e             kind;
    logic [CfgIndexW-1:0]  idx;
    logic [CfgDataW-1:0]   data;
    logic [ByteW-1:0]      tbyte;
    logic                  eot;
    logic [4:0]            reps;
    logic                  typed;
    logic                  hit;
    logic [PosW-1:0]       start;
  } script_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 text_valid_i  = 1'b0;
  logic [ByteW-1:0]     text_byte_i   = '0;
  logic                 end_of_text_i = 1'b0;
  logic                 match_stall_i = 1'b0;
  logic                 text_stall_o;
  logic                 match_valid_o;
  logic [PosW-1:0]      match_start_o;

  // Search state mirrored from the block
  logic [ByteW-1:0]     win_bytes [PatternMaxDef];
  int unsigned          win_fill  = 0;
  logic [PosW-1:0]      next_pos  = '0;
  logic [CfgDataW-1:0]  pat_lo_q  = '0;
  logic [CfgDataW-1:0]  pat_hi_q  = '0;
  logic [PatLenW-1:0]   pat_len_q = PatLenW'(1);

  logic [PosW-1:0]      expected_starts [$];
  script_row_t          script [$];
  int                   mismatch_count = 0;
  int                   tx_idle_pct    = 20;
  int                   rx_idle_pct    = 52;
  logic                 hold_req       = 1'b0;
  logic                 hold_taken     = 1'b0;
  int                   hold_left      = 0;
  int unsigned          cycle_count    = 0;
  logic [PosW-1:0]      got_start;

  bad_character_substring_search_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .text_valid_i  (text_valid_i),
    .text_stall_o  (text_stall_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .match_valid_o (match_valid_o),
    .match_stall_i (match_stall_i),
    .match_start_o (match_start_o)
  );

  // Free-running clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [PosW-1:0] got,
                                 input logic [PosW-1:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Advance the mirrored window by one text byte and decide whether a match ends here
  function automatic void search_step(input logic [ByteW-1:0] b, input logic eot,
                                      output logic hit, output logic [PosW-1:0] start);
    int unsigned n;
    int unsigned k;
    logic [2*CfgDataW-1:0] pat;
    pat = {pat_hi_q, pat_lo_q};
    n = (pat_len_q == 0) ? 1 : (pat_len_q > PatternMaxDef) ? PatternMaxDef : pat_len_q;
    for (k = PatternMaxDef - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
    win_bytes[0] = b;
    if (win_fill < PatternMaxDef) win_fill++;
    hit = (win_fill >= n);
    for (k = 0; k < n; k++) begin
      if (pat[8*k +: 8] != win_bytes[n-1-k]) hit = 1'b0;
    end
    start = next_pos - PosW'(n - 1);
    // End of text wipes the window after the check
    if (eot) begin
      for (k = 0; k < PatternMaxDef; k++) win_bytes[k] = '0;
      win_fill = 0;
      next_pos = '0;
    end else if (next_pos != '1) begin
      next_pos++;
    end
  endfunction

  function automatic void add_write(input logic [CfgIndexW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
    script_row_t row;
    row = '{ROW_WRITE, idx, data, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 32'd0};
    script.insert(script.size(), row);
  endfunction

  function automatic void add_text(input logic [ByteW-1:0] b, input logic eot,
                                   input logic [4:0] reps, input logic typed,
                                   input logic hit, input logic [PosW-1:0] start);
    script_row_t row;
    row = '{ROW_TEXT, CFG_PAT_LO, 64'd0, b, eot, reps, typed, hit, start};
    script.insert(script.size(), row);
  endfunction

  // Offer one byte, wait for the transaction, then log what should come out
  task automatic send_text(input logic [ByteW-1:0] b, input logic eot, input logic typed,
                           input logic want_hit, input logic [PosW-1:0] want_start);
    logic            hit;
    logic [PosW-1:0] start;
    text_valid_i  <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (text_stall_o) @(posedge clk_i);
    search_step(b, eot, hit, start);
    if (typed) begin
      hit   = want_hit;
      start = want_start;
    end
    if (hit) expected_starts.insert(expected_starts.size(), start);
    if ($urandom_range(99) < tx_idle_pct) begin
      text_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every match is out and the pipeline has settled
  task automatic drain_results();
    text_valid_i <= 1'b0;
    while (expected_starts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_PAT_LO:  pat_lo_q = data;
      CFG_PAT_HI:  pat_hi_q = data;
      CFG_PAT_LEN: pat_len_q = data[PatLenW-1:0];
      default: ;
    endcase
  endtask

  // Configure a random pattern, then stream text with planted, spoiled and noise bytes
  task automatic run_random_phase(input int n_items, input logic narrow_only,
                                  input logic hold_output);
    logic              narrow;
    logic [ByteW-1:0]  sym_a;
    logic [ByteW-1:0]  sym_b;
    logic [ByteW-1:0]  pat_bytes [PatternMaxDef];
    logic [ByteW-1:0]  b;
    logic [PatLenW-1:0] len_code;
    logic [CfgDataW-1:0] lo_word;
    logic [CfgDataW-1:0] hi_word;
    logic [CfgDataW-1:0] len_word;
    int                n_eff;
    int                spoil;
    int                k;
    int                sent;
    narrow = narrow_only || ($urandom_range(1) == 1);
    sym_a  = 8'($urandom_range(255));
    sym_b  = sym_a ^ 8'($urandom_range(1, 255));
    n_eff  = ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, PatternMaxDef);
    len_code = PatLenW'(n_eff);
    if (n_eff == 1 && $urandom_range(3) == 0) len_code = '0;
    if (n_eff == PatternMaxDef && $urandom_range(1) == 1) begin
      len_code = PatLenW'($urandom_range(PatternMaxDef + 1, 31));
    end
    for (k = 0; k < PatternMaxDef; k++) begin
      pat_bytes[k] = narrow ? (($urandom_range(1) == 1) ? sym_a : sym_b) : 8'($urandom);
    end
    for (k = 0; k < 8; k++) begin
      lo_word[8*k +: 8] = pat_bytes[k];
      hi_word[8*k +: 8] = pat_bytes[k+8];
    end
    len_word = {$urandom, $urandom};
    len_word[PatLenW-1:0] = len_code;

    drain_results();
    write_reg(CFG_PAT_LO, lo_word);
    write_reg(CFG_PAT_HI, hi_word);
    write_reg(CFG_PAT_LEN, len_word);
    if (hold_output) hold_req <= 1'b1;

    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 45) begin
        // Plant one occurrence, now and then with a byte spoiled
        spoil = ($urandom_range(99) < 15) ? $urandom_range(n_eff - 1) : -1;
        for (k = 0; k < n_eff; k++) begin
          b = pat_bytes[k];
          if (k == spoil) b = b ^ 8'($urandom_range(1, 255));
          send_text(b, $urandom_range(99) < 3, 1'b0, 1'b0, '0);
          sent++;
        end
      end else begin
        b = narrow ? (($urandom_range(1) == 1) ? sym_a : sym_b) : 8'($urandom);
        send_text(b, $urandom_range(99) < 5, 1'b0, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Output side: random stall, plus one long hold-off when requested
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      match_stall_i <= 1'b0;
    end else begin
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= HoldCycles;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      match_stall_i <= (hold_left > 1 || (hold_req && !hold_taken)) ? 1'b1 :
                       ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Compare each match transaction with the oldest pending start position
  always @(posedge clk_i) begin
    if (rst_ni && match_valid_o && !match_stall_i) begin
      if (expected_starts.size() == 0) begin
        report_mismatch("match with none pending", match_start_o, '0);
      end else begin
        got_start = expected_starts.pop_front();
        if (match_start_o !== got_start) report_mismatch("match_start", match_start_o, got_start);
      end
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int   r;
    int   n;
    int   seg;
    int   seg_items;
    int   phase_len;
    logic prev_text;

    for (r = 0; r < PatternMaxDef; r++) win_bytes[r] = '0;

    // Reset pattern is a single zero byte
    add_text(8'h00, 1'b0, 5'd1, 1'b1, 1'b1, 32'd0);
    add_text(8'hFF, 1'b1, 5'd1, 1'b1, 1'b0, 32'd0);
    add_text(8'h00, 1'b0, 5'd1, 1'b1, 1'b1, 32'd0);
    // A write to the unused index changes nothing
    add_write(CfgIdxSpare, '1);
    add_text(8'h00, 1'b0, 5'd1, 1'b1, 1'b1, 32'd1);
    // Overlapping pair, window kept across the writes
    add_write(CFG_PAT_LO, 64'h5555_5555_5555_AAAA);
    add_write(CFG_PAT_LEN, 64'd2);
    add_text(8'hAA, 1'b0, 5'd1, 1'b1, 1'b0, 32'd0);
    add_text(8'hAA, 1'b0, 5'd1, 1'b1, 1'b1, 32'd2);
    add_text(8'hAA, 1'b1, 5'd1, 1'b1, 1'b1, 32'd3);
    // Three bytes; no match until the window holds enough text
    add_write(CFG_PAT_LO, 64'h0000_0000_0043_4241);
    add_write(CFG_PAT_LEN, 64'd3);
    add_text(8'h41, 1'b0, 5'd1, 1'b1, 1'b0, 32'd0);
    add_text(8'h42, 1'b0, 5'd1, 1'b1, 1'b0, 32'd0);
    add_text(8'h43, 1'b1, 5'd1, 1'b1, 1'b1, 32'd0);
    // Length zero acts as one
    add_write(CFG_PAT_LEN, 64'd0);
    add_text(8'h41, 1'b1, 5'd1, 1'b1, 1'b1, 32'd0);
    // Oversized length clamps to the full window
    add_write(CFG_PAT_LO, '1);
    add_write(CFG_PAT_HI, '1);
    add_write(CFG_PAT_LEN, '1);
    add_text(8'hFF, 1'b0, 5'd15, 1'b0, 1'b0, 32'd0);
    add_text(8'hFF, 1'b1, 5'd1, 1'b1, 1'b1, 32'd0);

    // Hold reset, then release it
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed script
    prev_text = 1'b0;
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        if (prev_text) drain_results();
        prev_text = 1'b0;
        write_reg(script[i].idx, script[i].data);
      end else begin
        prev_text = 1'b1;
        for (n = 0; n < script[i].reps; n++) begin
          send_text(script[i].tbyte, script[i].eot, script[i].typed, script[i].hit,
                    script[i].start);
        end
      end
    end

    // Random streams under three idling mixes; the last opens with a long output hold
    for (seg = 0; seg < 3; seg++) begin
      tx_idle_pct = (seg == 0) ? 20 : (seg == 1) ? 52 : 0;
      rx_idle_pct = (seg == 0) ? 52 : (seg == 1) ? 20 : 0;
      seg_items   = 0;
      if (seg == 2) begin
        run_random_phase(80, 1'b1, 1'b1);
        seg_items = 80;
      end
      while (seg_items < RandomItems / 3) begin
        phase_len = $urandom_range(20, 60);
        run_random_phase(phase_len, 1'b0, 1'b0);
        seg_items += phase_len;
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/bcss_pkg.sv
rtl/core/bcss_cell.sv
rtl/core/bad_character_substring_search_unit.sv
sim/tb_bad_character_substring_search_unit.sv
